>>> rtl/pas_pkg.sv
// Shared types and constants for the particle animation step block.
// No dependencies; imported by the top level and the shared multiplier.
package pas_pkg;

  localparam int MUL_AW = 35;
  localparam int MUL_BW = 20;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SPAWN = 1'b1;

  localparam logic [1:0] MODE_BOUNCE_IN  = 2'd0;
  localparam logic [1:0] MODE_BOUNCE_OUT = 2'd1;
  localparam logic [1:0] MODE_CIRC_IN    = 2'd2;
  localparam logic [1:0] MODE_HOLD       = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DIV, S_MUL, S_SQRT, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_FSQ, OP_BF, OP_BM, OP_ANG, OP_DX, OP_DY,
    OP_VX, OP_VY, OP_PW, OP_W, OP_PH, OP_H
  } op_t;

  typedef enum logic [2:0] {
    REG_POS_X, REG_POS_Y, REG_VEL_X, REG_VEL_Y,
    REG_WIDTH, REG_HEIGHT, REG_SPIN, REG_LIFE
  } cfg_reg_t;

  typedef enum logic [1:0] {SEG_A, SEG_B, SEG_C, SEG_D} bo_seg_t;

  typedef struct packed {
    bo_seg_t            seg;
    logic signed [19:0] u;
  } bo_pre_t;

endpackage

>>> rtl/pas_div.sv
// Bit-serial restoring divider for the time fraction: num * 2^16 / den.
// Requires num <= den; 17 quotient bits, one per cycle. No dependencies.
module pas_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [16:0] quo
);

  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        first;
  logic        busy;
  logic [16:0] trial;
  logic        ge;

  assign trial = first ? rem : {rem[15:0], 1'b0};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= {1'b0, num};
        quo   <= '0;
        cnt   <= 5'd17;
        first <= 1'b1;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? trial - {1'b0, den} : trial;
        quo   <= {quo[15:0], ge};
        first <= 1'b0;
        cnt   <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/pas_sqrt.sv
// Digit-by-digit integer square root of a 33-bit value, 17 root bits,
// one per cycle. No dependencies.
module pas_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] x,
  output logic        done,
  output logic [16:0] root
);

  logic [33:0] xs;
  logic [20:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [20:0] rs;
  logic [20:0] tr;
  logic        ge;

  assign rs = {rem[18:0], xs[33:32]};
  assign tr = {2'b00, root, 2'b01};
  assign ge = rs >= tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= {1'b0, x};
        rem  <= '0;
        root <= '0;
        cnt  <= 5'd17;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? rs - tr : rs;
        root <= {root[15:0], ge};
        xs   <= {xs[31:0], 2'b00};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/pas_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pas_pkg for operand widths.
module pas_mul (
  input  logic                         clk,
  input  logic signed [pas_pkg::MUL_AW-1:0] a,
  input  logic signed [pas_pkg::MUL_BW-1:0] b,
  output logic signed [pas_pkg::MUL_PW-1:0] p
);
  import pas_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/particle_animation_step.sv
// Particle animation step: one request at a time. The work is done by the
// fraction divider, the square root, twelve passes through one multiplier
// and the load and handoff states. A stalled result holds the block; in_ready
// is high only while idle. Synchronous reset clears the particle state and
// loads the configuration defaults.
module particle_animation_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [15:0]        elapsed_ms,
  input  logic [1:0]         motion_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic [17:0]        out_width,
  output logic [17:0]        out_height,
  output logic signed [16:0] out_angle,
  output logic               is_alive
);
  import pas_pkg::*;

  function automatic bo_pre_t bo_pre(input logic [16:0] t);
    logic [20:0]        a;
    logic signed [21:0] u;
    bo_pre_t            r;
    a = {1'b0, t, 3'b000} + {3'b000, t, 1'b0} + {4'b0000, t};
    if (a < 21'd262144) begin
      r.seg = SEG_A;
      u = $signed({1'b0, a});
    end else if (a < 21'd524288) begin
      r.seg = SEG_B;
      u = $signed({1'b0, a}) - 22'sd393216;
    end else if (a < 21'd655360) begin
      r.seg = SEG_C;
      u = $signed({1'b0, a}) - 22'sd589824;
    end else begin
      r.seg = SEG_D;
      u = $signed({a, 1'b0}) - 22'sd1376256;
    end
    r.u = u[19:0];
    return r;
  endfunction

  function automatic logic [16:0] bo_post(input bo_seg_t seg, input logic [36:0] sq);
    logic [37:0] s;
    logic [17:0] r;
    case (seg)
      SEG_A: begin
        s = {1'b0, sq} + 38'd524288;
        r = s[37:20];
      end
      SEG_B: begin
        s = {1'b0, sq} + 38'd524288;
        r = 18'd49152 + s[37:20];
      end
      SEG_C: begin
        s = {1'b0, sq} + 38'd524288;
        r = 18'd61440 + s[37:20];
      end
      default: begin
        s = {1'b0, sq} + 38'd2097152;
        r = 18'd64512 + {2'b00, s[37:22]};
      end
    endcase
    return (r > {1'b0, ONE_Q16}) ? ONE_Q16 : r[16:0];
  endfunction

  function automatic logic signed [MUL_PW-1:0] rnd_shift(
    input logic signed [MUL_PW-1:0] x, input int unsigned sh);
    logic [MUL_PW-1:0] mag;
    logic [MUL_PW-1:0] r;
    mag = x[MUL_PW-1] ? MUL_PW'(-x) : MUL_PW'(x);
    r = (mag + (MUL_PW'(1) << (sh - 1))) >> sh;
    return x[MUL_PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [19:0] vel_delta(
    input logic [15:0] v, input logic signed [19:0] d2, input logic [1:0] mode);
    logic signed [19:0] sv;
    logic signed [19:0] r;
    sv = $signed({{4{v[15]}}, v});
    case (mode)
      MODE_BOUNCE_IN:  r = (sv <<< 3) - sv;
      MODE_BOUNCE_OUT: r = (sv <<< 2) + sv;
      MODE_CIRC_IN:    r = d2;
      default:         r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] size_fin(
    input logic [15:0] s, input logic signed [19:0] d, input logic [1:0] mode);
    logic signed [19:0] v;
    v = $signed({4'b0000, s}) + d;
    if (mode == MODE_HOLD) return {2'b00, s};
    if (v < 0) return '0;
    return v[17:0];
  endfunction

  // configuration
  logic [23:0] start_pos_x, start_pos_y;
  logic [15:0] start_vel_x, start_vel_y;
  logic [15:0] start_width, start_height;
  logic [16:0] spin_total;
  logic [15:0] life_span;

  // particle state
  logic [31:0]        age_ms;
  logic [23:0]        cur_pos_x, cur_pos_y;
  logic signed [19:0] cur_vel_x, cur_vel_y;
  logic [1:0]         mode_held;
  logic               live_flag;
  logic               cmd_q;

  state_t state, state_next;
  op_t    opc;
  logic   ph;

  logic [16:0]        f_q, circ_q, bf_q, bm_q;
  logic signed [16:0] ang_q;
  logic signed [19:0] dx_q, dy_q;
  logic [31:0]        prod_w, prod_h;
  logic [17:0]        wid_q, hei_q;

  logic        div_start, div_done, sq_start, sq_done;
  logic [16:0] div_quo, sq_root;
  logic [32:0] sq_x;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p, r16, r32;

  logic [15:0]        life_eff, amin;
  logic [32:0]        age_sum;
  logic [31:0]        age_new;
  logic [16:0]        pre_t;
  bo_pre_t            bo;
  logic [16:0]        e_sel;
  logic signed [19:0] m_sel, dsel_x, dsel_y;
  logic               in_acc, out_load;

  assign life_eff = (life_span == 16'd0) ? 16'd1 : life_span;
  assign amin     = (age_ms >= {16'b0, life_eff}) ? life_eff : age_ms[15:0];
  assign age_sum  = {1'b0, age_ms} + {17'b0, elapsed_ms};
  assign age_new  = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign pre_t  = (opc == OP_BM) ? ONE_Q16 - f_q : f_q;
  assign bo     = bo_pre(pre_t);
  assign dsel_x = vel_delta(start_vel_x, dx_q, mode_held);
  assign dsel_y = vel_delta(start_vel_y, dy_q, mode_held);
  assign m_sel  = (mode_held == MODE_BOUNCE_IN) ? -20'sd58982 : 20'sd131072;
  assign r16    = rnd_shift(mul_p, 16);
  assign r32    = rnd_shift(mul_p, 32);
  assign sq_x   = 33'h1_0000_0000 - mul_p[32:0];

  always_comb begin
    case (mode_held)
      MODE_BOUNCE_IN:  e_sel = ONE_Q16 - bm_q;
      MODE_BOUNCE_OUT: e_sel = bf_q;
      MODE_CIRC_IN:    e_sel = circ_q;
      default:         e_sel = '0;
    endcase
  end

  always_comb begin
    case (opc)
      OP_FSQ: begin
        mul_a = {18'b0, f_q};
        mul_b = {3'b000, f_q};
      end
      OP_BF, OP_BM: begin
        mul_a = {{15{bo.u[19]}}, bo.u};
        mul_b = bo.u;
      end
      OP_ANG: begin
        mul_a = {{18{spin_total[16]}}, spin_total};
        mul_b = {3'b000, bf_q};
      end
      OP_DX: begin
        mul_a = {{19{start_vel_x[15]}}, start_vel_x};
        mul_b = -20'sd6554;
      end
      OP_DY: begin
        mul_a = {{19{start_vel_y[15]}}, start_vel_y};
        mul_b = -20'sd6554;
      end
      OP_VX: begin
        mul_a = {{15{dsel_x[19]}}, dsel_x};
        mul_b = {3'b000, f_q};
      end
      OP_VY: begin
        mul_a = {{15{dsel_y[19]}}, dsel_y};
        mul_b = {3'b000, f_q};
      end
      OP_PW: begin
        mul_a = {19'b0, start_width};
        mul_b = {3'b000, e_sel};
      end
      OP_W: begin
        mul_a = {3'b000, prod_w};
        mul_b = m_sel;
      end
      OP_PH: begin
        mul_a = {19'b0, start_height};
        mul_b = {3'b000, e_sel};
      end
      OP_H: begin
        mul_a = {3'b000, prod_h};
        mul_b = m_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pas_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  pas_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(amin), .den(life_eff),
    .done(div_done), .quo(div_quo)
  );

  pas_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sq_x),
    .done(sq_done), .root(sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    sq_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_LOAD;
      end
      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_MUL;
      end
      S_MUL: begin
        if (ph) begin
          if (opc == OP_FSQ) begin
            sq_start   = 1'b1;
            state_next = S_SQRT;
          end else if (opc == OP_H) begin
            state_next = S_OUT;
          end
        end
      end
      S_SQRT: begin
        if (sq_done) state_next = S_MUL;
      end
      S_OUT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos_x  <= '0;
      start_pos_y  <= '0;
      start_vel_x  <= '0;
      start_vel_y  <= '0;
      start_width  <= 16'd256;
      start_height <= 16'd256;
      spin_total   <= '0;
      life_span    <= 16'd1000;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POS_X:  start_pos_x  <= cfg_data;
        REG_POS_Y:  start_pos_y  <= cfg_data;
        REG_VEL_X:  start_vel_x  <= cfg_data[15:0];
        REG_VEL_Y:  start_vel_y  <= cfg_data[15:0];
        REG_WIDTH:  start_width  <= cfg_data[15:0];
        REG_HEIGHT: start_height <= cfg_data[15:0];
        REG_SPIN:   spin_total   <= cfg_data[16:0];
        REG_LIFE:   life_span    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // particle state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      age_ms    <= '0;
      cur_pos_x <= '0;
      cur_pos_y <= '0;
      cur_vel_x <= '0;
      cur_vel_y <= '0;
      mode_held <= '0;
      live_flag <= 1'b0;
      cmd_q     <= 1'b0;
      opc       <= OP_FSQ;
      ph        <= 1'b0;
    end else begin
      if (in_acc) begin
        cmd_q <= command;
        if (command == CMD_SPAWN) begin
          cur_pos_x <= start_pos_x;
          cur_pos_y <= start_pos_y;
          cur_vel_x <= {{4{start_vel_x[15]}}, start_vel_x};
          cur_vel_y <= {{4{start_vel_y[15]}}, start_vel_y};
          mode_held <= motion_mode;
          age_ms    <= '0;
          live_flag <= 1'b1;
        end else begin
          age_ms    <= age_new;
          if (age_new >= {16'b0, life_eff}) live_flag <= 1'b0;
          cur_pos_x <= cur_pos_x + {{4{cur_vel_x[19]}}, cur_vel_x};
          cur_pos_y <= cur_pos_y + {{4{cur_vel_y[19]}}, cur_vel_y};
        end
      end
      if (state == S_DIV && div_done) begin
        f_q <= div_quo;
        opc <= OP_FSQ;
        ph  <= 1'b0;
      end
      if (state == S_SQRT && sq_done) circ_q <= ONE_Q16 - sq_root;
      if (state == S_MUL) begin
        ph <= ~ph;
        if (ph) begin
          if (opc != OP_H) opc <= op_t'(opc + 4'd1);
          case (opc)
            OP_BF:  bf_q  <= bo_post(bo.seg, mul_p[36:0]);
            OP_BM:  bm_q  <= bo_post(bo.seg, mul_p[36:0]);
            OP_ANG: ang_q <= r16[16:0];
            OP_DX:  dx_q  <= r16[19:0];
            OP_DY:  dy_q  <= r16[19:0];
            OP_VX:  if (cmd_q != CMD_SPAWN)
                      cur_vel_x <= $signed({{4{start_vel_x[15]}}, start_vel_x}) + r16[19:0];
            OP_VY:  if (cmd_q != CMD_SPAWN)
                      cur_vel_y <= $signed({{4{start_vel_y[15]}}, start_vel_y}) + r16[19:0];
            OP_PW:  prod_w <= mul_p[31:0];
            OP_W:   wid_q  <= size_fin(start_width, r32[19:0], mode_held);
            OP_PH:  prod_h <= mul_p[31:0];
            OP_H:   hei_q  <= size_fin(start_height, r32[19:0], mode_held);
            default: ;
          endcase
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_x  <= cur_pos_x;
      out_pos_y  <= cur_pos_y;
      out_width  <= wid_q;
      out_height <= hei_q;
      out_angle  <= ang_q;
      is_alive   <= live_flag;
    end
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider finished outside divide phase");

  a_sqrt_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQRT) else $error("square root finished outside its phase");

  a_spawn_live: assert property (@(posedge clk) disable iff (rst)
    (in_acc && command == CMD_SPAWN) |=> live_flag) else $error("spawn did not set live");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> f_q <= ONE_Q16) else $error("time fraction above one");

endmodule
